>>> rtl/core/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int unsigned QW       = 16;
  localparam int unsigned VW       = 32;
  localparam int unsigned PW       = 2 * QW;
  localparam int unsigned MW       = PW + 2;
  localparam int unsigned NW       = PW + 1;
  localparam int unsigned AW       = MW + VW;
  localparam int unsigned LANES    = 3;
  localparam int unsigned MTX      = LANES * LANES;
  localparam int unsigned DIV_STEP = 4;
  localparam int unsigned DIV_STG  = VW / DIV_STEP;
  localparam int unsigned CIW      = 2;

  typedef enum logic [CIW-1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
    logic signed [VW-1:0] vec_w;
  } vec_t;

  typedef struct packed {
    logic signed [VW-1:0] rot_x;
    logic signed [VW-1:0] rot_y;
    logic signed [VW-1:0] rot_z;
    logic signed [VW-1:0] rot_w;
    logic                 zero_quat;
    logic                 clipped;
  } rot_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] w;
  } quat_t;

  typedef struct packed {
    logic [MTX-1:0][MW-1:0] m;
    logic [NW-1:0]          n;
    logic                   zero;
  } coef_t;

  typedef struct packed {
    logic [NW-1:0]        n;
    logic                 zero;
    logic signed [VW-1:0] vec_w;
  } side_t;

endpackage

>>> rtl/core/quaternion_vector_rotate.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates Q16.16 vectors by a Q1.14 quaternion as q*v*conj(q) / |q|^2.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o  | vec_t
//   out     | output    | out_valid_o / out_stall_i | rot_t
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One beat enters every cycle unless the output stalls. Each beat passes the
// two matrix stages, three multiply-accumulate stages and the divider, which
// resolves four quotient bits per stage. Reset clears all valid bits and loads
// the identity quaternion. A stall on the output freezes the whole pipeline.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  qvr_pkg::vec_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output qvr_pkg::rot_t             out_data_o,
  input  logic                      cfg_we_i,
  input  logic [qvr_pkg::CIW-1:0]   cfg_idx_i,
  input  logic [qvr_pkg::QW-1:0]    cfg_wdata_i
);
  import qvr_pkg::*;

  quat_t quat_q;
  logic  en;
  logic  c_valid, m_valid;
  coef_t c_coef;
  vec_t  c_vec;
  logic [LANES-1:0][AW-1:0] m_acc;
  side_t m_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q.x <= '0;
      quat_q.y <= '0;
      quat_q.z <= '0;
      quat_q.w <= QW'(16384);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_QUAT_X: quat_q.x <= cfg_wdata_i;
        REG_QUAT_Y: quat_q.y <= cfg_wdata_i;
        REG_QUAT_Z: quat_q.z <= cfg_wdata_i;
        REG_QUAT_W: quat_q.w <= cfg_wdata_i;
        default:    quat_q   <= quat_q;
      endcase
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  qvr_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .quat_i  (quat_q),
    .vec_i   (in_data_i),
    .valid_o (c_valid),
    .coef_o  (c_coef),
    .vec_o   (c_vec)
  );

  qvr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid),
    .coef_i  (c_coef),
    .vec_i   (c_vec),
    .valid_o (m_valid),
    .acc_o   (m_acc),
    .side_o  (m_side)
  );

  qvr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_valid),
    .acc_i   (m_acc),
    .side_i  (m_side),
    .valid_o (out_valid_o),
    .rot_o   (out_data_o)
  );

  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_quat |->
      out_data_o.rot_x == '0 && out_data_o.rot_y == '0 &&
      out_data_o.rot_z == '0 && !out_data_o.clipped)
    else $error("zero quaternion beat carries data");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      out_data_o.rot_x == 32'h7FFF_FFFF || out_data_o.rot_x == 32'h8000_0000 ||
      out_data_o.rot_y == 32'h7FFF_FFFF || out_data_o.rot_y == 32'h8000_0000 ||
      out_data_o.rot_z == 32'h7FFF_FFFF || out_data_o.rot_z == 32'h8000_0000)
    else $error("clipped beat without saturated component");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(c_valid) && $stable(m_valid))
    else $error("pipeline moved while stalled");

endmodule

>>> rtl/core/qvr_coef.sv
// ----------------------------------------------------------------------------
// qvr_coef
// Two stages that turn the quaternion into a rotation matrix and norm.
// ----------------------------------------------------------------------------
module qvr_coef (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  qvr_pkg::quat_t quat_i,
  input  qvr_pkg::vec_t  vec_i,
  output logic           valid_o,
  output qvr_pkg::coef_t coef_o,
  output qvr_pkg::vec_t  vec_o
);
  import qvr_pkg::*;

  logic signed [PW-1:0] xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic                 v1_q, v2_q;
  vec_t                 vec1_q, vec2_q;
  coef_t                coef_d, coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q   <= quat_i.x * quat_i.x;
      yy_q   <= quat_i.y * quat_i.y;
      zz_q   <= quat_i.z * quat_i.z;
      ww_q   <= quat_i.w * quat_i.w;
      xy_q   <= quat_i.x * quat_i.y;
      xz_q   <= quat_i.x * quat_i.z;
      yz_q   <= quat_i.y * quat_i.z;
      wx_q   <= quat_i.w * quat_i.x;
      wy_q   <= quat_i.w * quat_i.y;
      wz_q   <= quat_i.w * quat_i.z;
      vec1_q <= vec_i;
      coef_q <= coef_d;
      vec2_q <= vec1_q;
    end
  end

  always_comb begin
    logic signed [MW-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;
    exx = MW'(xx_q);
    eyy = MW'(yy_q);
    ezz = MW'(zz_q);
    eww = MW'(ww_q);
    exy = MW'(xy_q);
    exz = MW'(xz_q);
    eyz = MW'(yz_q);
    ewx = MW'(wx_q);
    ewy = MW'(wy_q);
    ewz = MW'(wz_q);
    coef_d.m[0] = eww + exx - eyy - ezz;
    coef_d.m[1] = (exy - ewz) <<< 1;
    coef_d.m[2] = (exz + ewy) <<< 1;
    coef_d.m[3] = (exy + ewz) <<< 1;
    coef_d.m[4] = eww - exx + eyy - ezz;
    coef_d.m[5] = (eyz - ewx) <<< 1;
    coef_d.m[6] = (exz - ewy) <<< 1;
    coef_d.m[7] = (eyz + ewx) <<< 1;
    coef_d.m[8] = eww - exx - eyy + ezz;
    coef_d.n    = NW'(exx + eyy + ezz + eww);
    coef_d.zero = (coef_d.n == '0);
  end

  assign valid_o = v2_q;
  assign coef_o  = coef_q;
  assign vec_o   = vec2_q;

endmodule

>>> rtl/core/qvr_mac.sv
// ----------------------------------------------------------------------------
// qvr_mac
// Three stages of matrix times vector with split partial products.
// ----------------------------------------------------------------------------
module qvr_mac (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  qvr_pkg::coef_t               coef_i,
  input  qvr_pkg::vec_t                vec_i,
  output logic                         valid_o,
  output logic [qvr_pkg::LANES-1:0][qvr_pkg::AW-1:0] acc_o,
  output qvr_pkg::side_t               side_o
);
  import qvr_pkg::*;

  localparam int unsigned HW  = VW / 2;
  localparam int unsigned LPW = MW + HW + 1;
  localparam int unsigned HPW = MW + HW;
  localparam int unsigned LSW = LPW + 2;
  localparam int unsigned HSW = HPW + 2;

  logic signed [LPW-1:0] pl_q [MTX];
  logic signed [HPW-1:0] ph_q [MTX];
  logic signed [LSW-1:0] sl_q [LANES];
  logic signed [HSW-1:0] sh_q [LANES];
  logic [LANES-1:0][AW-1:0] acc_q;
  logic [2:0]            v_q;
  side_t                 s1_q, s2_q, s3_q;
  logic [LANES-1:0][VW-1:0] vv;

  assign vv[0] = vec_i.vec_x;
  assign vv[1] = vec_i.vec_y;
  assign vv[2] = vec_i.vec_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < MTX; i++) begin
        pl_q[i] <= $signed(coef_i.m[i]) * $signed({1'b0, vv[i % LANES][HW-1:0]});
        ph_q[i] <= $signed(coef_i.m[i]) * $signed(vv[i % LANES][VW-1:HW]);
      end
      for (int r = 0; r < LANES; r++) begin
        sl_q[r] <= LSW'(pl_q[r*LANES]) + LSW'(pl_q[r*LANES+1]) + LSW'(pl_q[r*LANES+2]);
        sh_q[r] <= HSW'(ph_q[r*LANES]) + HSW'(ph_q[r*LANES+1]) + HSW'(ph_q[r*LANES+2]);
        acc_q[r] <= (AW'(sh_q[r]) <<< HW) + AW'(sl_q[r]);
      end
      s1_q <= '{n: coef_i.n, zero: coef_i.zero, vec_w: vec_i.vec_w};
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  assign valid_o = v_q[2];
  assign acc_o   = acc_q;
  assign side_o  = s3_q;

endmodule

>>> rtl/core/qvr_div.sv
// ----------------------------------------------------------------------------
// qvr_div
// Pipelined restoring divider by the norm with saturation, three lanes.
// ----------------------------------------------------------------------------
module qvr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [qvr_pkg::LANES-1:0][qvr_pkg::AW-1:0] acc_i,
  input  qvr_pkg::side_t               side_i,
  output logic                         valid_o,
  output qvr_pkg::rot_t                rot_o
);
  import qvr_pkg::*;

  localparam int unsigned GW = AW - 1;

  logic [GW-1:0]       mag_q [LANES];
  logic [LANES-1:0]    neg_q;
  logic                vm_q;
  side_t               sm_q;

  logic [NW-1:0]       rem_q [DIV_STG+1][LANES];
  logic [VW-1:0]       quo_q [DIV_STG+1][LANES];
  logic [LANES-1:0]    sgn_q [DIV_STG+1];
  logic [LANES-1:0]    ovf_q [DIV_STG+1];
  logic                val_q [DIV_STG+1];
  side_t               sd_q  [DIV_STG+1];

  logic                out_valid_q;
  rot_t                rot_q, rot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q     <= 1'b0;
      val_q[0] <= 1'b0;
    end else if (en_i) begin
      vm_q     <= valid_i;
      val_q[0] <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        neg_q[l] <= acc_i[l][AW-1];
        mag_q[l] <= acc_i[l][AW-1] ? GW'(-acc_i[l]) : GW'(acc_i[l]);
        ovf_q[0][l] <= (mag_q[l][GW-1:VW] >= sm_q.n);
        rem_q[0][l] <= mag_q[l][GW-1:VW];
        quo_q[0][l] <= mag_q[l][VW-1:0];
      end
      sm_q     <= side_i;
      sgn_q[0] <= neg_q;
      sd_q[0]  <= sm_q;
    end
  end

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stage
    logic [NW-1:0] rem_d [LANES];
    logic [VW-1:0] quo_d [LANES];

    always_comb begin
      logic [NW:0] r2;
      for (int l = 0; l < LANES; l++) begin
        rem_d[l] = rem_q[s][l];
        quo_d[l] = quo_q[s][l];
        for (int k = 0; k < DIV_STEP; k++) begin
          r2 = {rem_d[l], quo_d[l][VW-1]};
          if (r2 >= {1'b0, sd_q[s].n}) begin
            r2       = r2 - {1'b0, sd_q[s].n};
            quo_d[l] = {quo_d[l][VW-2:0], 1'b1};
          end else begin
            quo_d[l] = {quo_d[l][VW-2:0], 1'b0};
          end
          rem_d[l] = r2[NW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[s+1] <= 1'b0;
      end else if (en_i) begin
        val_q[s+1] <= val_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[s+1][l] <= rem_d[l];
          quo_q[s+1][l] <= quo_d[l];
        end
        sgn_q[s+1] <= sgn_q[s];
        ovf_q[s+1] <= ovf_q[s];
        sd_q[s+1]  <= sd_q[s];
      end
    end
  end

  always_comb begin
    logic [LANES-1:0][VW-1:0] res;
    logic [LANES-1:0]         clip;
    logic [VW-1:0]            q;
    for (int l = 0; l < LANES; l++) begin
      q = quo_q[DIV_STG][l];
      if (sgn_q[DIV_STG][l]) begin
        clip[l] = ovf_q[DIV_STG][l] || (q > {1'b1, {(VW-1){1'b0}}});
        res[l]  = clip[l] ? {1'b1, {(VW-1){1'b0}}} : -q;
      end else begin
        clip[l] = ovf_q[DIV_STG][l] || q[VW-1];
        res[l]  = clip[l] ? {1'b0, {(VW-1){1'b1}}} : q;
      end
      if (sd_q[DIV_STG].zero) begin
        clip[l] = 1'b0;
        res[l]  = '0;
      end
    end
    rot_d.rot_x     = res[0];
    rot_d.rot_y     = res[1];
    rot_d.rot_z     = res[2];
    rot_d.rot_w     = sd_q[DIV_STG].vec_w;
    rot_d.zero_quat = sd_q[DIV_STG].zero;
    rot_d.clipped   = |clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= val_q[DIV_STG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = out_valid_q;
  assign rot_o   = rot_q;

endmodule

>>> bench/tb_quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_vector_rotate
// Streams vectors through the rotator under a series of quaternion settings,
// including identity, zero, full-scale and random ones. A local predictor
// computes each rotated beat with wide exact arithmetic, and the monitor
// checks every output beat in order. The sender idles in bursts, and the
// receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_quaternion_vector_rotate;
  import qvr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  vec_t                in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rot_t                out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CIW-1:0]      cfg_idx_i = REG_QUAT_X;
  logic [QW-1:0]       cfg_wdata_i = '0;

  quat_t       quat_now;
  vec_t        pending_vecs[$];
  rot_t        rotated_due[$];
  bit          failed = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned cycle_cnt = 0;

  quaternion_vector_rotate dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic rot_t rotate_vec(vec_t v, quat_t q);
    logic signed [127:0] x, y, z, w, n, acc, quo;
    logic signed [127:0] m[3][3];
    logic signed [127:0] vv[3];
    logic signed [31:0]  res[3];
    rot_t r;
    x = q.x;
    y = q.y;
    z = q.z;
    w = q.w;
    vv[0] = v.vec_x;
    vv[1] = v.vec_y;
    vv[2] = v.vec_z;
    n = x * x + y * y + z * z + w * w;
    r = '0;
    r.rot_w = v.vec_w;
    if (n == 0) begin
      r.zero_quat = 1'b1;
      return r;
    end
    m[0][0] = w * w + x * x - y * y - z * z;
    m[0][1] = 2 * (x * y - w * z);
    m[0][2] = 2 * (x * z + w * y);
    m[1][0] = 2 * (x * y + w * z);
    m[1][1] = w * w - x * x + y * y - z * z;
    m[1][2] = 2 * (y * z - w * x);
    m[2][0] = 2 * (x * z - w * y);
    m[2][1] = 2 * (y * z + w * x);
    m[2][2] = w * w - x * x - y * y + z * z;
    for (int i = 0; i < 3; i++) begin
      acc = m[i][0] * vv[0] + m[i][1] * vv[1] + m[i][2] * vv[2];
      quo = acc / n;
      if (quo > 128'sd2147483647) begin
        res[i] = 32'h7FFFFFFF;
        r.clipped = 1'b1;
      end else if (quo < -128'sd2147483648) begin
        res[i] = 32'h80000000;
        r.clipped = 1'b1;
      end else begin
        res[i] = quo[31:0];
      end
    end
    r.rot_x = res[0];
    r.rot_y = res[1];
    r.rot_z = res[2];
    return r;
  endfunction

  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 9))
      6: return 32'h7FFFFFFF;
      7: return 32'h80000000;
      8: return $signed($urandom) >>> 12;
      9: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Sender: bursts of beats separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rotated_due.push_back(rotate_vec(in_data_i, quat_now));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          burst_left = $urandom_range(1, 30);
        end
        if (gap_left > 0 || pending_vecs.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          burst_left--;
          in_valid_i <= 1'b1;
          in_data_i  <= pending_vecs.pop_front();
        end
      end
    end
  end

  // Receiver: stall pattern is redrawn at random from four modes; accepted beats are checked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycle_cnt++;
      if (cycle_cnt % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= (cycle_cnt % 8) < 3;
      endcase
      if (out_valid_o && !out_stall_i) begin
        if (rotated_due.size() == 0) begin
          $error("output beat with nothing expected");
          failed = 1'b1;
        end else begin
          rot_t e;
          e = rotated_due.pop_front();
          if (out_data_o.rot_x !== e.rot_x) begin
            $error("rot_x expected %0d actual %0d", e.rot_x, out_data_o.rot_x);
            failed = 1'b1;
          end
          if (out_data_o.rot_y !== e.rot_y) begin
            $error("rot_y expected %0d actual %0d", e.rot_y, out_data_o.rot_y);
            failed = 1'b1;
          end
          if (out_data_o.rot_z !== e.rot_z) begin
            $error("rot_z expected %0d actual %0d", e.rot_z, out_data_o.rot_z);
            failed = 1'b1;
          end
          if (out_data_o.rot_w !== e.rot_w) begin
            $error("rot_w expected %0d actual %0d", e.rot_w, out_data_o.rot_w);
            failed = 1'b1;
          end
          if (out_data_o.zero_quat !== e.zero_quat) begin
            $error("zero_quat expected %0b actual %0b", e.zero_quat,
                   out_data_o.zero_quat);
            failed = 1'b1;
          end
          if (out_data_o.clipped !== e.clipped) begin
            $error("clipped expected %0b actual %0b", e.clipped, out_data_o.clipped);
            failed = 1'b1;
          end
        end
      end
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("tb_quaternion_vector_rotate NOT OK");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_vecs.size() != 0 || rotated_due.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic load_quat(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                           logic [15:0] qw);
    logic [15:0] vals[4];
    vals = '{qx, qy, qz, qw};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= reg_idx_e'(i);
      cfg_wdata_i <= vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    quat_now = '{x: qx, y: qy, z: qz, w: qw};
  endtask

  task automatic queue_directed();
    vec_t v;
    pending_vecs.push_back('0);
    pending_vecs.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
    pending_vecs.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
    pending_vecs.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'hFFFFFFFF});
    pending_vecs.push_back('{32'h00010000, 32'h0, 32'h0, 32'h12345678});
    pending_vecs.push_back('{32'h0, 32'hFFFF0000, 32'h0, 32'h0});
    pending_vecs.push_back('{32'h0, 32'h0, 32'h80000000, 32'h80000000});
    v = '{$urandom, $urandom, $urandom, $urandom};
    pending_vecs.push_back(v);
  endtask

  task automatic queue_random(int unsigned count);
    vec_t v;
    for (int i = 0; i < count; i++) begin
      v.vec_x = pick_component();
      v.vec_y = pick_component();
      v.vec_z = pick_component();
      v.vec_w = $urandom;
      pending_vecs.push_back(v);
    end
  endtask

  initial begin
    quat_now = '{x: 16'd0, y: 16'd0, z: 16'd0, w: 16'd16384};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    queue_random(105);
    wait_idle();

    load_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_directed();
    queue_random(105);
    wait_idle();

    load_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_directed();
    queue_random(105);
    wait_idle();

    load_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_random(105);
    wait_idle();

    load_quat(16'h0000, 16'h0000, 16'd11585, 16'd11585);
    queue_random(105);
    wait_idle();

    load_quat(16'h8000, 16'h0001, 16'h7FFF, 16'h0000);
    queue_random(105);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      load_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      queue_random(105);
      wait_idle();
    end

    if (!failed) begin
      $display("tb_quaternion_vector_rotate OK");
    end else begin
      $display("tb_quaternion_vector_rotate NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/qvr_pkg.sv
rtl/core/qvr_coef.sv
rtl/core/qvr_mac.sv
rtl/core/qvr_div.sv
rtl/core/quaternion_vector_rotate.sv
bench/tb_quaternion_vector_rotate.sv
